// ----- rtl/core/eas_pkg.sv -----
// ----------------------------------------------------------------------------
// EWMA anomaly score alarm package
// Shared types, register codes, reset values and constants of the block.
// ----------------------------------------------------------------------------
package eas_pkg;

  localparam int unsigned NUM_RULES = 4;

  // Register codes of the configuration port.
  typedef enum logic [1:0] {
    REG_RULE_ENABLE      = 2'd0,
    REG_SCORE_THRESHOLD  = 2'd1,
    REG_DEVIATION_MARGIN = 2'd2
  } cfg_reg_e;

  localparam logic [3:0] RULE_ENABLE_RST      = 4'd15;
  localparam logic [7:0] SCORE_THRESHOLD_RST  = 8'd40;
  localparam logic [7:0] DEVIATION_MARGIN_RST = 8'd15;

  localparam logic [6:0] LOW_ENERGY_LIMIT = 7'd20;
  localparam logic [8:0] SCORE_MAX        = 9'd255;

  // Outcome counter slots.
  typedef enum logic [1:0] {
    OUT_TRUE_POS  = 2'd0,
    OUT_FALSE_POS = 2'd1,
    OUT_TRUE_NEG  = 2'd2,
    OUT_FALSE_NEG = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [3:0] rule_enable;
    logic [7:0] score_threshold;
    logic [7:0] deviation_margin;
  } cfg_t;

  typedef struct packed {
    logic [NUM_RULES-1:0][7:0] signal;
    logic [6:0]                energy_percent;
    logic                      attack_truth;
  } item_t;

  typedef struct packed {
    logic [7:0] score;
    logic       alarm;
  } verdict_t;

  // Weight of each rule in the score sum.
  function automatic logic [1:0] rule_weight(input logic [1:0] rule);
    logic [1:0] w;
    unique case (rule)
      2'd0:    w = 2'd3;
      2'd1:    w = 2'd2;
      default: w = 2'd1;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/eas_in_if.sv -----
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying one monitoring tick.
// ----------------------------------------------------------------------------
interface eas_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rank_signal;
  logic [7:0] forward_signal;
  logic [7:0] flood_signal;
  logic [7:0] tunnel_signal;
  logic [6:0] energy_percent;
  logic       attack_truth;

  modport source (
    output valid, rank_signal, forward_signal, flood_signal, tunnel_signal,
           energy_percent, attack_truth,
    input  ready
  );
  modport sink (
    input  valid, rank_signal, forward_signal, flood_signal, tunnel_signal,
           energy_percent, attack_truth,
    output ready
  );
endinterface

// ----- rtl/core/eas_out_if.sv -----
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying the score, alarm and outcome counters.
// ----------------------------------------------------------------------------
interface eas_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  score;
  logic        alarm;
  logic [31:0] true_pos;
  logic [31:0] false_pos;
  logic [31:0] true_neg;
  logic [31:0] false_neg;

  modport source (
    output valid, score, alarm, true_pos, false_pos, true_neg, false_neg,
    input  ready
  );
  modport sink (
    input  valid, score, alarm, true_pos, false_pos, true_neg, false_neg,
    output ready
  );
endinterface

// ----- rtl/core/eas_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration channel interface
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface eas_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/eas_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// Holds rule enables, score threshold and deviation margin.
// ----------------------------------------------------------------------------
module eas_cfg_regs
  import eas_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [7:0] wr_data,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_RULE_ENABLE:      cfg_nxt.rule_enable      = wr_data[3:0];
        REG_SCORE_THRESHOLD:  cfg_nxt.score_threshold  = wr_data;
        REG_DEVIATION_MARGIN: cfg_nxt.deviation_margin = wr_data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rule_enable      <= RULE_ENABLE_RST;
      cfg_r.score_threshold  <= SCORE_THRESHOLD_RST;
      cfg_r.deviation_margin <= DEVIATION_MARGIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/eas_score.sv -----
// ----------------------------------------------------------------------------
// Baseline and score unit
// Per-rule EWMA baselines, detection and the weighted, saturated score, halved at low energy.
// ----------------------------------------------------------------------------
module eas_score
  import eas_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     commit,
  input  item_t    item,
  input  cfg_t     cfg,
  output verdict_t verdict
);

  logic [NUM_RULES-1:0][7:0] base_r;
  logic [NUM_RULES-1:0][7:0] base_nxt;
  logic [10:0]               sum;
  logic [8:0]                quarter;
  logic [7:0]                sat;
  logic [7:0]                score;

  always_comb begin
    logic [7:0]  raw;
    logic [10:0] acc;
    logic [8:0]  bound;
    sum = '0;
    for (int i = 0; i < NUM_RULES; i++) begin
      raw         = cfg.rule_enable[i] ? item.signal[i] : 8'd0;
      // 7*old + raw, then divide by eight
      acc         = {base_r[i], 3'b000} - {3'b000, base_r[i]} + {3'b000, raw};
      base_nxt[i] = acc[10:3];
      bound       = {1'b0, base_nxt[i]} + {1'b0, cfg.deviation_margin};
      if ({1'b0, raw} > bound) begin
        sum = sum + ({3'b000, raw} * {9'd0, rule_weight(2'(i))});
      end
    end
  end

  assign quarter = sum[10:2];
  assign sat     = (quarter > SCORE_MAX) ? SCORE_MAX[7:0] : quarter[7:0];
  assign score   = (item.energy_percent < LOW_ENERGY_LIMIT) ? {1'b0, sat[7:1]} : sat;

  assign verdict.score = score;
  assign verdict.alarm = score > cfg.score_threshold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (commit) begin
      base_r <= base_nxt;
    end
  end

endmodule

// ----- rtl/core/eas_tally.sv -----
// ----------------------------------------------------------------------------
// Outcome counters
// Four wrapping 32-bit confusion counters, one bumped per committed tick.
// ----------------------------------------------------------------------------
module eas_tally
  import eas_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        commit,
  input  logic        alarm,
  input  logic        attack,
  output logic [31:0] true_pos,
  output logic [31:0] false_pos,
  output logic [31:0] true_neg,
  output logic [31:0] false_neg
);

  logic [3:0][31:0] cnt_r;
  outcome_e         slot;

  always_comb begin
    priority if (alarm && attack) begin
      slot = OUT_TRUE_POS;
    end else if (alarm) begin
      slot = OUT_FALSE_POS;
    end else if (attack) begin
      slot = OUT_FALSE_NEG;
    end else begin
      slot = OUT_TRUE_NEG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (commit) begin
      cnt_r[slot] <= cnt_r[slot] + 32'd1;
    end
  end

  assign true_pos  = cnt_r[OUT_TRUE_POS];
  assign false_pos = cnt_r[OUT_FALSE_POS];
  assign true_neg  = cnt_r[OUT_TRUE_NEG];
  assign false_neg = cnt_r[OUT_FALSE_NEG];

endmodule

// ----- rtl/core/ewma_anomaly_score_alarm.sv -----
// ----------------------------------------------------------------------------
// EWMA anomaly score alarm
// Top level: configuration registers, input register, score unit, outcome counters, result register.
// ----------------------------------------------------------------------------
// The block takes one monitoring tick per transaction and returns exactly one
// result transaction for it. A tick enters an input register and is committed
// once the result register is empty or its contents are being taken; then the
// four baselines are updated, the weighted score and the alarm are formed and
// one outcome counter is bumped, all at the same edge that loads the result
// register. A new tick can be accepted in every cycle as long as results are
// taken; each tick needs the baselines left by the one before, and these are
// updated at the commit edge. When the result is not taken, the input register
// still holds one more tick. Configuration writes are always accepted and take
// effect on the next tick computed; they should only be issued while no tick
// is in flight. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module ewma_anomaly_score_alarm
  import eas_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  eas_in_if.sink     in_ch,
  eas_out_if.source  out_ch,
  eas_cfg_if.sink    cfg_ch
);

  cfg_t     cfg;
  verdict_t verdict;
  item_t    item_r;
  logic     in_valid_r;
  logic     in_valid_nxt;
  logic     out_valid_r;
  logic     out_valid_nxt;
  verdict_t verdict_r;
  logic     commit;
  logic     in_take;

  // Configuration writes never stall.
  assign cfg_ch.ready = 1'b1;

  eas_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // A tick in the input register is committed when the result register is
  // empty or its contents are being taken in this cycle.
  assign commit       = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || commit;
  assign in_take      = in_ch.valid && in_ch.ready;

  assign in_valid_nxt  = in_take || (in_valid_r && !commit);
  assign out_valid_nxt = commit || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.signal[0]      <= in_ch.rank_signal;
      item_r.signal[1]      <= in_ch.forward_signal;
      item_r.signal[2]      <= in_ch.flood_signal;
      item_r.signal[3]      <= in_ch.tunnel_signal;
      item_r.energy_percent <= in_ch.energy_percent;
      item_r.attack_truth   <= in_ch.attack_truth;
    end
    if (commit) begin
      verdict_r <= verdict;
    end
  end

  eas_score u_score (
    .clk     (clk),
    .rst_n   (rst_n),
    .commit  (commit),
    .item    (item_r),
    .cfg     (cfg),
    .verdict (verdict)
  );

  // The counters change only at the edge that loads the result register, so
  // their current values always belong to the result on offer.
  eas_tally u_tally (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (commit),
    .alarm     (verdict.alarm),
    .attack    (item_r.attack_truth),
    .true_pos  (out_ch.true_pos),
    .false_pos (out_ch.false_pos),
    .true_neg  (out_ch.true_neg),
    .false_neg (out_ch.false_neg)
  );

  assign out_ch.valid = out_valid_r;
  assign out_ch.score = verdict_r.score;
  assign out_ch.alarm = verdict_r.alarm;

  logic [31:0] cnt_total;
  assign cnt_total = out_ch.true_pos + out_ch.false_pos + out_ch.true_neg
                   + out_ch.false_neg;

  // Every committed tick bumps exactly one counter.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> cnt_total == $past(cnt_total) + 32'd1)
    else $error("outcome counters did not advance by one on commit");

  // Counters hold when nothing is committed.
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> cnt_total == $past(cnt_total))
    else $error("outcome counters changed without a commit");

  // A waiting tick is never dropped.
  a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !commit) |=> in_valid_r)
    else $error("tick in input register lost");

  // A result is produced only from a committed tick.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_ch.ready) && !commit |=> !out_valid_r)
    else $error("result offered without a committed tick");

endmodule
